// File: hw/rtl/lra_pkg.sv
// Shared types and constants for the linear interpolation resampler.
package lra_pkg;

    localparam int SAMPLE_W          = 16;
    localparam int STEP_W            = 35;
    localparam int CH_W              = 2;
    localparam int CFG_IDX_W         = 2;
    localparam int FRACTION_BITS_DEF = 32;
    localparam int MAX_RUN           = 16;
    localparam int CNT_W             = $clog2(MAX_RUN + 1);
    localparam int QUEUE_DEPTH       = 4;
    localparam int QUEUE_AW          = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW          = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_CH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_CH = 2'd2;

    localparam logic [CH_W-1:0] CH_MONO = 2'd1;
    localparam logic [CH_W-1:0] CH_STEREO = 2'd2;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // one source frame as handed from the front to the back
    typedef struct packed {
        t_sample prev_first;
        t_sample prev_second;
        t_sample cur_first;
        t_sample cur_second;
        logic    restart;
        logic    emit;
    } t_job;

    typedef struct packed {
        logic [STEP_W-1:0] step;
        logic              mono_in;
        logic              mono_out;
    } t_cfg;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

endpackage

// File: hw/rtl/lra_front.sv
// Front end: accepts source frames, tracks the held frame, builds jobs.
module lra_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  lra_pkg::t_sample i_first_sample,
    input  lra_pkg::t_sample i_second_sample,
    input  logic             i_restart,
    output logic             o_push,
    output lra_pkg::t_job    o_job,
    input  logic             i_queue_full
);
    import lra_pkg::*;

    t_sample r_held_first;
    t_sample r_held_second;
    logic    r_held_valid;
    logic    w_accept;

    assign o_in_stall = i_queue_full;
    assign w_accept   = i_in_valid && !i_queue_full;
    assign o_push     = w_accept;

    always_comb begin
        o_job.prev_first  = r_held_first;
        o_job.prev_second = r_held_second;
        o_job.cur_first   = i_first_sample;
        o_job.cur_second  = i_second_sample;
        o_job.restart     = i_restart;
        // a restart drops the held frame, so this word only gets stored
        o_job.emit        = r_held_valid && !i_restart;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
        end else if (w_accept) begin
            r_held_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_held_first  <= i_first_sample;
            r_held_second <= i_second_sample;
        end
    end

endmodule

// File: hw/rtl/lra_queue.sv
// Short job queue between the front and the back.
module lra_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lra_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output lra_pkg::t_job o_job
);
    import lra_pkg::*;

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr;
    logic [QUEUE_AW-1:0] r_rd;
    logic [QUEUE_CW-1:0] r_cnt;

    assign o_full  = (r_cnt == QUEUE_CW'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// File: hw/rtl/lra_back.sv
// Back end: phase stepping, interpolation and channel mapping.
module lra_back #(
    parameter int FRACTION_BITS = lra_pkg::FRACTION_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lra_pkg::t_cfg    i_cfg,
    input  logic             i_job_valid,
    input  lra_pkg::t_job    i_job,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output lra_pkg::t_sample o_out_first,
    output lra_pkg::t_sample o_out_second,
    output logic             o_last_of_run
);
    import lra_pkg::*;

    localparam int PH_W   = STEP_W + 1;
    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int PROD_W = DIFF_W + FRACTION_BITS + 1;
    localparam logic [PH_W-1:0] ONE = {{(PH_W-1){1'b0}}, 1'b1} << FRACTION_BITS;

    t_state r_state, n_state;

    logic [STEP_W-1:0]       r_phase, n_phase;
    logic [PH_W-1:0]         r_ph, n_ph;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    t_sample                 r_a0, r_a1;
    logic signed [DIFF_W-1:0] r_d0, r_d1;
    logic                    r_out_valid, n_out_valid;
    t_sample                 r_out_first, n_out_first;
    t_sample                 r_out_second, n_out_second;
    logic                    r_last, n_last;

    logic                      w_slot;
    logic                      w_done;
    logic                      w_emit;
    logic [PH_W-1:0]           w_ph_next;
    logic [FRACTION_BITS-1:0]  w_frac;
    logic signed [PROD_W-1:0]  w_prod0, w_prod1;
    logic signed [DIFF_W-1:0]  w_c0, w_c1;
    logic signed [DIFF_W-1:0]  w_sum, w_sum_adj;
    logic                      w_load;

    assign o_out_valid   = r_out_valid;
    assign o_out_first   = r_out_first;
    assign o_out_second  = r_out_second;
    assign o_last_of_run = r_last;

    assign w_slot    = !r_out_valid || !i_out_stall;
    assign w_done    = (r_ph >= ONE) || (r_cnt == CNT_W'(MAX_RUN));
    assign w_ph_next = r_ph + {1'b0, i_cfg.step};
    assign w_frac    = r_ph[FRACTION_BITS-1:0];

    // signed product, then arithmetic shift gives the floor
    assign w_prod0 = r_d0 * $signed({1'b0, w_frac});
    assign w_prod1 = r_d1 * $signed({1'b0, w_frac});
    assign w_c0 = {r_a0[SAMPLE_W-1], r_a0} + w_prod0[FRACTION_BITS+DIFF_W-1:FRACTION_BITS];
    assign w_c1 = {r_a1[SAMPLE_W-1], r_a1} + w_prod1[FRACTION_BITS+DIFF_W-1:FRACTION_BITS];

    // average with truncation toward zero
    assign w_sum     = {w_c0[SAMPLE_W-1], w_c0[SAMPLE_W-1:0]}
                     + {w_c1[SAMPLE_W-1], w_c1[SAMPLE_W-1:0]};
    assign w_sum_adj = w_sum + {{(DIFF_W-1){1'b0}}, w_sum[DIFF_W-1]};

    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_ph         = r_ph;
        n_cnt        = r_cnt;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_first  = r_out_first;
        n_out_second = r_out_second;
        n_last       = r_last;
        o_pop        = 1'b0;
        w_emit       = 1'b0;
        w_load       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    o_pop = 1'b1;
                    if (i_job.emit) begin
                        w_load  = 1'b1;
                        n_ph    = {1'b0, r_phase};
                        n_cnt   = '0;
                        n_state = S_RUN;
                    end else if (i_job.restart) begin
                        n_phase = '0;
                    end
                end
            end
            S_RUN: begin
                if (w_done) begin
                    n_phase = (r_ph >= ONE) ? STEP_W'(r_ph - ONE) : '0;
                    n_state = S_IDLE;
                end else if (w_slot) begin
                    w_emit      = 1'b1;
                    n_ph        = w_ph_next;
                    n_cnt       = r_cnt + 1'b1;
                    n_out_valid = 1'b1;
                    n_last      = (w_ph_next >= ONE) || (r_cnt == CNT_W'(MAX_RUN - 1));
                    if (i_cfg.mono_in) begin
                        n_out_first  = w_c0[SAMPLE_W-1:0];
                        n_out_second = w_c0[SAMPLE_W-1:0];
                    end else if (i_cfg.mono_out) begin
                        n_out_first  = w_sum_adj[DIFF_W-1:1];
                        n_out_second = w_sum_adj[DIFF_W-1:1];
                    end else begin
                        n_out_first  = w_c0[SAMPLE_W-1:0];
                        n_out_second = w_c1[SAMPLE_W-1:0];
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= '0;
            r_ph        <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_ph        <= n_ph;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_a0 <= i_job.prev_first;
            r_a1 <= i_job.prev_second;
            r_d0 <= {i_job.cur_first[SAMPLE_W-1], i_job.cur_first}
                  - {i_job.prev_first[SAMPLE_W-1], i_job.prev_first};
            r_d1 <= {i_job.cur_second[SAMPLE_W-1], i_job.cur_second}
                  - {i_job.prev_second[SAMPLE_W-1], i_job.prev_second};
        end
        if (w_emit) begin
            r_out_first  <= n_out_first;
            r_out_second <= n_out_second;
            r_last       <= n_last;
        end
    end

endmodule

// File: hw/rtl/linear_interp_resampler.sv
// Top level of the linear interpolation resampler: config registers and wiring.
//
//  word      direction  handshake               payload
//  -------   ---------  ----------------------  ------------------------------------
//  in        input      i_in_valid/o_in_stall   first_sample, second_sample, restart
//  out       output     o_out_valid/i_out_stall out_first, out_second, last_of_run
//  cfg       input      i_cfg_valid/o_cfg_ready cfg_index, cfg_data
//
//  The front takes one input word a cycle while the job queue has room.
//  The back pops a store-only word and stays in IDLE; a word that yields N
//  output words (N up to 16) is held in RUN, one word a cycle unless stalled.
//  Synchronous reset clears held frame, phase and queue and resets the config.
//  An output stall holds the back; the queue then fills and stalls the input.
module linear_interp_resampler #(
    parameter int FRACTION_BITS = lra_pkg::FRACTION_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [lra_pkg::SAMPLE_W-1:0] i_first_sample,
    input  logic signed [lra_pkg::SAMPLE_W-1:0] i_second_sample,
    input  logic                                i_restart,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [lra_pkg::SAMPLE_W-1:0] o_out_first,
    output logic signed [lra_pkg::SAMPLE_W-1:0] o_out_second,
    output logic                                o_last_of_run,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lra_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lra_pkg::STEP_W-1:0]          i_cfg_data
);
    import lra_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [CH_W-1:0]   r_in_ch;
    logic [CH_W-1:0]   r_out_ch;
    t_cfg              w_cfg;

    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_qvalid;
    t_job w_job_in;
    t_job w_job_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= STEP_W'(1) << FRACTION_BITS;
            r_in_ch  <= CH_STEREO;
            r_out_ch <= CH_STEREO;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_STEP:   r_step   <= i_cfg_data;
                CFG_IN_CH:  r_in_ch  <= i_cfg_data[CH_W-1:0];
                CFG_OUT_CH: r_out_ch <= i_cfg_data[CH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // codes other than mono act as stereo
    always_comb begin
        w_cfg.step     = r_step;
        w_cfg.mono_in  = (r_in_ch == CH_MONO);
        w_cfg.mono_out = (r_out_ch == CH_MONO);
    end

    lra_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_first_sample (i_first_sample),
        .i_second_sample(i_second_sample),
        .i_restart      (i_restart),
        .o_push         (w_push),
        .o_job          (w_job_in),
        .i_queue_full   (w_full)
    );

    lra_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_job  (w_job_in),
        .o_full (w_full),
        .i_pop  (w_pop),
        .o_valid(w_qvalid),
        .o_job  (w_job_out)
    );

    lra_back #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_job_valid  (w_qvalid),
        .i_job        (w_job_out),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_first  (o_out_first),
        .o_out_second (o_out_second),
        .o_last_of_run(o_last_of_run)
    );

endmodule
